// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: hw/rtl/bbd_pkg.sv
// types, constants and arithmetic helpers of the bernstein basis core
package bbd_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int X_W           = FRAC_BITS + 1;
  localparam int ORD_W         = 4;
  localparam int VAL_W         = 17;
  localparam int D1_W          = 21;
  localparam int D2_W          = 24;
  localparam int ORDER_LIM     = 12;
  localparam int DEF_MAX_ORDER = 8;
  localparam int CW            = 10;
  localparam int K_W           = 9;
  localparam int CK_W          = 20;
  localparam int ACC_W         = 40;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [X_W-1:0]   X_ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ORD_W-1:0] ORDER_RESET = 4'd2;
  localparam logic [ADDR_W-3:0] REG_BASIS_ORDER = 1'b0;

  typedef logic [ORDER_LIM:0][ORDER_LIM:0][CW-1:0] pascal_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [ORD_W-1:0] order;
  } point_t;

  typedef enum logic [1:0] {PW_IDLE, PW_BUILD, PW_DONE} pw_state_t;

  // pascal triangle, evaluated at elaboration
  function automatic pascal_t pascal_table();
    pascal_t t;
    t = '0;
    for (int n = 0; n <= ORDER_LIM; n++) begin
      t[n][0] = CW'(1);
      for (int k = 1; k <= n; k++) begin
        t[n][k] = t[n-1][k-1] + t[n-1][k];
      end
    end
    return t;
  endfunction

  // fixed point product, truncated
  function automatic logic [X_W-1:0] fx_mul(input logic [X_W-1:0] a,
                                            input logic [X_W-1:0] b);
    logic [2*X_W-1:0] pr;
    pr = a * b;
    return pr[FRAC_BITS +: X_W];
  endfunction

  function automatic logic [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1]) return '0;
    if (v[ACC_W-1:VAL_W] != '0) return '1;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic [D1_W-1:0] sat_d1(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:D1_W-1] == '0 || v[ACC_W-1:D1_W-1] == '1) return v[D1_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(D1_W-1){1'b0}}} : {1'b0, {(D1_W-1){1'b1}}};
  endfunction

  function automatic logic [D2_W-1:0] sat_d2(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:D2_W-1] == '0 || v[ACC_W-1:D2_W-1] == '1) return v[D2_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(D2_W-1){1'b0}}} : {1'b0, {(D2_W-1){1'b1}}};
  endfunction

endpackage

// File: hw/rtl/bbd_front.sv
// front end: order register, point intake with clamping, two-word queue
`include "assert_macros.svh"
module bbd_front import bbd_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              point_valid,
  output logic              point_stall,
  input  logic [X_W-1:0]    point_x,
  output logic              q_valid,
  input  logic              q_take,
  output point_t            q_item
);

  logic [ORD_W-1:0] order;
  point_t           mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  point_t           in_item;

  assign pready = 1'b1;
  assign prdata = {{(DATA_W-ORD_W){1'b0}}, order};

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_BASIS_ORDER) begin
      order <= pwdata[ORD_W-1:0];
    end
  end

  always_comb begin
    in_item.x     = (point_x > X_ONE) ? X_ONE : point_x;
    in_item.order = (order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order;
  end

  assign point_stall = (count == 2'd2);
  assign push        = point_valid && !point_stall;
  assign q_valid     = (count != 2'd0);
  assign pop         = q_take && q_valid;
  assign q_item      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

  `ASSERT_CLK(a_fill, clk, rst, push && !pop |=> count == $past(count) + 2'd1, "queue fill lost a word")

endmodule

// File: hw/rtl/bbd_power.sv
// builds the powers of (1-x) for one point, one step a cycle
`include "assert_macros.svh"
module bbd_power import bbd_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_take,
  input  point_t                          item,
  output logic                            hand_valid,
  input  logic                            hand_take,
  output point_t                          hand_item,
  output logic [MAX_ORDER:0][X_W-1:0]     hand_q
);

  pw_state_t                   state;
  pw_state_t                   state_next;
  logic                        load;
  logic [ORD_W-1:0]            cnt;
  logic [X_W-1:0]              cur;
  logic [X_W-1:0]              y;
  logic [X_W-1:0]              newy;
  logic [MAX_ORDER:0][X_W-1:0] q;
  point_t                      pt;

  assign load = item_valid && (state == PW_IDLE || (state == PW_DONE && hand_take));
  assign newy = fx_mul(cur, y);

  always_comb begin
    state_next = state;
    unique case (state)
      PW_IDLE: begin
        if (load) state_next = (item.order == '0) ? PW_DONE : PW_BUILD;
      end
      PW_BUILD: begin
        if (cnt + ORD_W'(1) == pt.order) state_next = PW_DONE;
      end
      PW_DONE: begin
        if (load) state_next = (item.order == '0) ? PW_DONE : PW_BUILD;
        else if (hand_take) state_next = PW_IDLE;
      end
      default: state_next = PW_IDLE;
    endcase
  end

  always_comb begin
    hand_valid = (state == PW_DONE);
    item_take  = load;
    hand_item  = pt;
    hand_q     = q;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= PW_IDLE;
    else state <= state_next;
  end

  // q[0] always holds the newest power, so q[k] ends as (1-x)^(p-k)
  always_ff @(posedge clk) begin
    if (load) begin
      pt   <= item;
      y    <= X_ONE - item.x;
      cur  <= X_ONE;
      cnt  <= '0;
      q    <= {{(MAX_ORDER*X_W){1'b0}}, X_ONE};
    end else if (state == PW_BUILD) begin
      cur <= newy;
      q   <= {q[MAX_ORDER-1:0], newy};
      cnt <= cnt + ORD_W'(1);
    end
  end

  `ASSERT_CLK(a_hold, clk, rst, state == PW_DONE && !hand_take |=> state == PW_DONE && $stable(q), "powers changed before handoff")

endmodule

// File: hw/rtl/bbd_emit.sv
// sweeps basis indices and evaluates value and derivatives in three stages
`include "assert_macros.svh"
module bbd_emit import bbd_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hand_valid,
  output logic                        hand_take,
  input  point_t                      hand_item,
  input  logic [MAX_ORDER:0][X_W-1:0] hand_q,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [ORD_W-1:0]            basis_index,
  output logic [VAL_W-1:0]            basis_value,
  output logic signed [D1_W-1:0]      first_derivative,
  output logic signed [D2_W-1:0]      second_derivative,
  output logic                        last_of_point
);

  localparam pascal_t PASCAL = pascal_table();

  logic en;
  logic last0;

  // sweep state
  logic                          busy;
  logic [ORD_W-1:0]              idx;
  logic [ORD_W-1:0]              ord;
  logic [X_W-1:0]                xv;
  logic [X_W-1:0]                pxc;
  logic [X_W-1:0]                pm1;
  logic [X_W-1:0]                pm2;
  logic [MAX_ORDER+2:0][X_W-1:0] win;

  // stage one
  logic                   v1;
  logic [X_W-1:0]         m1_0, m1_1, m1_2, m1_3, m1_4, m1_5;
  logic [CW-1:0]          c1;
  logic signed [K_W-1:0]  k1a, k1b, k2a, k2b, k2c;
  logic [ORD_W-1:0]       idx1;
  logic                   last1;

  // stage two
  logic                   v2;
  logic [X_W-1:0]         m2_0, m2_1, m2_2, m2_3, m2_4, m2_5;
  logic [CW-1:0]          c2;
  logic signed [CK_W-1:0] ck1a, ck1b, ck2a, ck2b, ck2c;
  logic [ORD_W-1:0]       idx2;
  logic                   last2;

  logic signed [K_W-1:0]   di, dd;
  logic signed [CW:0]      cs;
  logic signed [X_W:0]     s0, s1, s2, s3, s4, s5;
  logic signed [ACC_W-1:0] n_acc, g_acc, g2_acc;

  assign en        = !(result_valid && result_stall);
  assign last0     = (idx == ord);
  assign hand_take = hand_valid && en && (!busy || last0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en) begin
      if (hand_take) busy <= 1'b1;
      else if (busy && last0) busy <= 1'b0;
    end
  end

  // window slides so that win[0..2] are (1-x)^(p-i), ^(p-i-1), ^(p-i-2)
  always_ff @(posedge clk) begin
    if (hand_take) begin
      idx <= '0;
      ord <= hand_item.order;
      xv  <= hand_item.x;
      pxc <= X_ONE;
      pm1 <= '0;
      pm2 <= '0;
      win <= {{(2*X_W){1'b0}}, hand_q};
    end else if (en && busy) begin
      idx <= idx + ORD_W'(1);
      pm2 <= pm1;
      pm1 <= pxc;
      pxc <= fx_mul(pxc, xv);
      win <= {{X_W{1'b0}}, win[MAX_ORDER+2:1]};
    end
  end

  // zero-coefficient terms may use any power, their weight cancels them
  always_comb begin
    di = K_W'(signed'({1'b0, idx}));
    dd = di - K_W'(signed'({1'b0, ord}));
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= busy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_0  <= fx_mul(pxc, win[0]);
      m1_1  <= fx_mul(pxc, win[1]);
      m1_2  <= fx_mul(pm1, win[0]);
      m1_3  <= fx_mul(pm1, win[1]);
      m1_4  <= fx_mul(pm2, win[0]);
      m1_5  <= fx_mul(pxc, win[2]);
      c1    <= PASCAL[ord][idx];
      k1a   <= dd;
      k1b   <= di;
      k2a   <= K_W'(2) * di * dd;
      k2b   <= di * (di - K_W'(1));
      k2c   <= (dd + K_W'(1)) * dd;
      idx1  <= idx;
      last1 <= last0;
    end
  end

  assign cs = signed'({1'b0, c1});

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_0  <= m1_0;
      m2_1  <= m1_1;
      m2_2  <= m1_2;
      m2_3  <= m1_3;
      m2_4  <= m1_4;
      m2_5  <= m1_5;
      c2    <= c1;
      ck1a  <= CK_W'(cs) * CK_W'(k1a);
      ck1b  <= CK_W'(cs) * CK_W'(k1b);
      ck2a  <= CK_W'(cs) * CK_W'(k2a);
      ck2b  <= CK_W'(cs) * CK_W'(k2b);
      ck2c  <= CK_W'(cs) * CK_W'(k2c);
      idx2  <= idx1;
      last2 <= last1;
    end
  end

  always_comb begin
    s0 = signed'({1'b0, m2_0});
    s1 = signed'({1'b0, m2_1});
    s2 = signed'({1'b0, m2_2});
    s3 = signed'({1'b0, m2_3});
    s4 = signed'({1'b0, m2_4});
    s5 = signed'({1'b0, m2_5});
    n_acc  = ACC_W'(signed'({1'b0, c2})) * ACC_W'(s0);
    g_acc  = ACC_W'(ck1a) * ACC_W'(s1) + ACC_W'(ck1b) * ACC_W'(s2);
    g2_acc = ACC_W'(ck2a) * ACC_W'(s3) + ACC_W'(ck2b) * ACC_W'(s4)
           + ACC_W'(ck2c) * ACC_W'(s5);
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      basis_index       <= idx2;
      basis_value       <= sat_val(n_acc);
      first_derivative  <= sat_d1(g_acc);
      second_derivative <= sat_d2(g2_acc);
      last_of_point     <= last2;
    end
  end

  `ASSERT_NEVER(a_idx, clk, rst, busy && (idx > ord), "basis index ran past the order")
  `ASSERT_CLK(a_start, clk, rst, busy && !$past(busy) |-> idx == '0, "sweep did not start at index zero")
  `ASSERT_CLK(a_end, clk, rst, busy && en && last0 && !hand_valid |=> !busy, "sweep did not end after the last index")

endmodule

// File: hw/rtl/bernstein_basis_with_derivatives_core.sv
// top level: bernstein basis values with first and second derivatives
// throughput: one result word per cycle while result_stall is low; the index sweep of the evaluator
// overlaps the power build of the next point
// reset: synchronous rst empties the queue and pipeline and sets basis_order to 2
module bernstein_basis_with_derivatives_core import bbd_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   point_valid,
  output logic                   point_stall,
  input  logic [X_W-1:0]         point_x,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [ORD_W-1:0]       basis_index,
  output logic [VAL_W-1:0]       basis_value,
  output logic signed [D1_W-1:0] first_derivative,
  output logic signed [D2_W-1:0] second_derivative,
  output logic                   last_of_point
);

  logic                        q_valid;
  logic                        q_take;
  point_t                      q_item;
  logic                        hand_valid;
  logic                        hand_take;
  point_t                      hand_item;
  logic [MAX_ORDER:0][X_W-1:0] hand_q;

  bbd_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .point_valid, .point_stall, .point_x,
    .q_valid, .q_take, .q_item
  );

  bbd_power #(.MAX_ORDER(MAX_ORDER)) u_power (
    .clk, .rst,
    .item_valid(q_valid), .item_take(q_take), .item(q_item),
    .hand_valid, .hand_take, .hand_item, .hand_q
  );

  bbd_emit #(.MAX_ORDER(MAX_ORDER)) u_emit (
    .clk, .rst, .hand_valid, .hand_take, .hand_item, .hand_q,
    .result_valid, .result_stall, .basis_index, .basis_value,
    .first_derivative, .second_derivative, .last_of_point
  );

endmodule

// File: tb/bernstein_basis_with_derivatives_core_tb.sv
// testbench of the bernstein basis core: predicted result words checked against the outputs
module bernstein_basis_with_derivatives_core_tb import bbd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = DEF_MAX_ORDER;

  typedef struct {
    logic [ORD_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [D1_W-1:0]  d1;
    logic [D2_W-1:0]  d2;
    logic             last;
  } basis_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic point_valid = 1'b0;
  logic point_stall;
  logic [X_W-1:0] point_x = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [ORD_W-1:0] basis_index;
  logic [VAL_W-1:0] basis_value;
  logic signed [D1_W-1:0] first_derivative;
  logic signed [D2_W-1:0] second_derivative;
  logic last_of_point;

  logic [X_W-1:0] pending_points[$];
  basis_word_t expected_words[$];
  logic [3:0] order_reg = ORDER_RESET;
  int errors = 0;
  bit calm = 1'b0;
  bit in_taken = 1'b0;

  always #5 clk = ~clk;

  bernstein_basis_with_derivatives_core u_top (.*);

  function automatic longint trunc_term(longint pxa[MAXP+1], longint pyb[MAXP+1],
                                        int a, int b);
    return (pxa[a < 0 ? 0 : a] * pyb[b < 0 ? 0 : b]) >>> FRAC_BITS;
  endfunction

  function automatic longint sat_s(longint v, int w);
    longint mx;
    mx = (longint'(1) << (w - 1)) - 1;
    if (v > mx) return mx;
    if (v < -mx - 1) return -mx - 1;
    return v;
  endfunction

  // expected basis words of one point at the current order
  task automatic predict_basis(input logic [X_W-1:0] xin);
    longint one, xv, n, g, g2, c;
    longint pxa[MAXP+1];
    longint pyb[MAXP+1];
    longint bn[MAXP+1];
    int p;
    basis_word_t w;
    one = longint'(1) << FRAC_BITS;
    xv = xin;
    if (xv > one) xv = one;
    p = order_reg > MAXP ? MAXP : int'(order_reg);
    pxa[0] = one;
    pyb[0] = one;
    for (int k = 1; k <= p; k++) begin
      pxa[k] = (pxa[k-1] * xv) >>> FRAC_BITS;
      pyb[k] = (pyb[k-1] * (one - xv)) >>> FRAC_BITS;
    end
    bn[0] = 1;
    for (int k = 1; k <= p; k++) begin
      bn[k] = 1;
      for (int j = k - 1; j >= 1; j--) bn[j] = bn[j] + bn[j-1];
    end
    for (int i = 0; i <= p; i++) begin
      c = bn[i];
      n = c * trunc_term(pxa, pyb, i, p - i);
      g = c * ((i - p) * trunc_term(pxa, pyb, i, p - i - 1)
               + i * trunc_term(pxa, pyb, i - 1, p - i));
      g2 = c * (2 * i * (i - p) * trunc_term(pxa, pyb, i - 1, p - i - 1)
                + i * (i - 1) * trunc_term(pxa, pyb, i - 2, p - i)
                + (i - p + 1) * (i - p) * trunc_term(pxa, pyb, i, p - i - 2));
      w.idx = ORD_W'(i);
      w.val = VAL_W'(n < 0 ? 0 : (n > 131071 ? 131071 : n));
      w.d1 = D1_W'(sat_s(g, D1_W));
      w.d2 = D2_W'(sat_s(g2, D2_W));
      w.last = (i == p);
      expected_words.push_back(w);
    end
  endtask

  // input handshake seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk) begin
    in_taken <= !rst && point_valid && !point_stall;
  end

  // driver: a word stays on the port until it is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        predict_basis(point_x);
        void'(pending_points.pop_front());
      end
      if (point_valid && !in_taken) begin
        point_valid <= 1'b1;
      end else if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
        point_valid <= 1'b1;
        point_x <= pending_points[0];
      end else begin
        point_valid <= 1'b0;
      end
      result_stall <= !calm && $urandom_range(99) < 19;
    end
  end

  // monitor: checks each accepted result word
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        basis_word_t e;
        e = expected_words.pop_front();
        if (basis_index !== e.idx) begin
          $error("basis_index exp %0d got %0d", e.idx, basis_index); errors++;
        end
        if (basis_value !== e.val) begin
          $error("basis_value exp %0d got %0d", e.val, basis_value); errors++;
        end
        if (first_derivative !== e.d1) begin
          $error("first_derivative exp %0d got %0d", $signed(e.d1), first_derivative);
          errors++;
        end
        if (second_derivative !== e.d2) begin
          $error("second_derivative exp %0d got %0d", $signed(e.d2), second_derivative);
          errors++;
        end
        if (last_of_point !== e.last) begin
          $error("last_of_point exp %0d got %0d", e.last, last_of_point); errors++;
        end
      end
    end
  end

  task automatic write_order(input logic [3:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    order_reg = v;
    if (prdata !== DATA_W'(v)) begin
      $error("prdata exp %0d got %0d", v, prdata); errors++;
    end
  endtask

  task automatic run_phase(input logic [3:0] ord, input int count, input bit directed);
    logic [X_W-1:0] v;
    if (ord != order_reg) write_order(ord);
    if (directed) begin
      pending_points.push_back(X_W'(0));
      pending_points.push_back(X_ONE);
      pending_points.push_back(X_ONE >> 1);
      pending_points.push_back(17'h1ffff);
      pending_points.push_back(17'h10001);
      pending_points.push_back(17'h0ffff);
      pending_points.push_back(X_W'(1));
    end
    for (int k = 0; k < count; k++) begin
      v = ($urandom_range(9) == 0) ? X_W'($urandom) : X_W'($urandom_range(65536));
      pending_points.push_back(v);
    end
    while (pending_points.size() > 0 || point_valid || expected_words.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_phase(4'd2, 2, 1'b1);
    run_phase(4'd0, 4, 1'b1);
    run_phase(4'd8, 25, 1'b1);
    run_phase(4'd15, 6, 1'b0);
    run_phase(4'd1, 15, 1'b0);
    calm = 1'b1;
    run_phase(4'd5, 20, 1'b0);
    calm = 1'b0;
    run_phase(4'd3, 20, 1'b0);
    run_phase(4'd7, 10, 1'b0);
    if (errors == 0) begin
      $display("bernstein_basis_with_derivatives_core_tb OK");
    end else begin
      $display("bernstein_basis_with_derivatives_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("bernstein_basis_with_derivatives_core_tb NOT OK");
    $finish;
  end

endmodule
